// ----- hw/rtl/b2a_pkg.sv -----
package b2a_pkg;

    // Widest number of digits that padded mode may ask for.
    localparam int MAX_DIGITS = 10;

    localparam int VALUE_W    = 32;
    localparam int BYTE_W     = 8;
    localparam int BCD_DIGITS = (MAX_DIGITS > 10) ? MAX_DIGITS : 10;
    localparam int BCD_W      = 4 * BCD_DIGITS;
    localparam int POS_W      = $clog2(BCD_DIGITS);
    localparam int CNT_W      = $clog2(BCD_DIGITS + 1);
    localparam int BIT_CNT_W  = $clog2(VALUE_W);

    localparam logic [7:0] ASCII_ZERO  = 8'd48;
    localparam logic [7:0] ASCII_MINUS = 8'd45;

    typedef enum logic [1:0] {
        OP_SIGNED_DEC = 2'd0,
        OP_BYTE_DEC   = 2'd1,
        OP_PADDED_DEC = 2'd2,
        OP_BYTE_BIN   = 2'd3
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [VALUE_W-1:0] value;
        logic [3:0]         digit_count;
    } request_t;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last;
    } result_t;

endpackage

// ----- hw/rtl/binary_to_ascii_number_formatter.sv -----
// Channel   Handshake        Payload              Notes
// request   start / busy     request (request_t)  taken when start is high and busy low
// result    strobe           result (result_t)    valid for one cycle, cannot be held off
//
// A request takes a set-up step, then serial shift-and-add-3 conversion of all
// 32 value bits into a BCD register, one bit a cycle, then a pass over the ten
// digit positions while digits are emitted or skipped. Byte binary skips the
// conversion and steps through its eight bits instead. Reset clears the
// sequencer and the strobe; the receiver cannot stall, so every result is
// shown for exactly one cycle.
module binary_to_ascii_number_formatter (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  b2a_pkg::request_t  request,
    output logic               strobe,
    output b2a_pkg::result_t   result
);
    import b2a_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_EMIT
    } state_t;

    state_t                state_reg,   state_next;
    op_t                   op_reg,      op_next;
    logic [VALUE_W-1:0]    bin_reg,     bin_next;
    logic [BCD_W-1:0]      bcd_reg,     bcd_next;
    logic [BIT_CNT_W-1:0]  bit_cnt_reg, bit_cnt_next;
    logic [POS_W-1:0]      pos_reg,     pos_next;
    logic [CNT_W-1:0]      keep_reg,    keep_next;
    logic                  seen_reg,    seen_next;
    logic                  strobe_reg,  strobe_next;
    result_t               result_reg,  result_next;

    logic [BCD_W-1:0]      bcd_adj;
    logic [3:0]            top_digit;
    logic                  emit;

    // Add three to every BCD digit of five or more before the shift. The digits
    // are independent of one another.
    always_comb
    begin
        for (int i = 0; i < BCD_DIGITS; i++)
        begin
            if (bcd_reg[4*i +: 4] >= 4'd5)
            begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            end
            else
            begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4];
            end
        end
    end

    assign top_digit = bcd_reg[BCD_W-1 -: 4];

    // Decide whether the digit position now at the top of the BCD register is
    // printed. Leading zeros are dropped until the units digit, which always
    // prints; padded mode prints only the low positions it was asked for.
    always_comb
    begin
        case (op_reg)
            OP_PADDED_DEC: emit = (CNT_W'(pos_reg) < keep_reg);
            OP_BYTE_BIN:   emit = 1'b1;
            default:       emit = seen_reg || (top_digit != 4'd0) || (pos_reg == '0);
        endcase
    end

    always_comb
    begin
        state_next   = state_reg;
        op_next      = op_reg;
        bin_next     = bin_reg;
        bcd_next     = bcd_reg;
        bit_cnt_next = bit_cnt_reg;
        pos_next     = pos_reg;
        keep_next    = keep_reg;
        seen_next    = seen_reg;
        strobe_next  = 1'b0;
        result_next  = result_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    op_next      = request.op;
                    bcd_next     = '0;
                    bit_cnt_next = '0;
                    seen_next    = 1'b0;
                    pos_next     = POS_W'(BCD_DIGITS - 1);
                    state_next   = ST_CONV;

                    if (CNT_W'(request.digit_count) > CNT_W'(MAX_DIGITS))
                    begin
                        keep_next = CNT_W'(MAX_DIGITS);
                    end
                    else
                    begin
                        keep_next = CNT_W'(request.digit_count);
                    end

                    case (request.op)
                        OP_SIGNED_DEC:
                        begin
                            if (request.value[VALUE_W-1])
                            begin
                                // The magnitude is taken unsigned, so the most
                                // negative value converts correctly.
                                bin_next               = '0 - request.value;
                                strobe_next            = 1'b1;
                                result_next.char_code  = ASCII_MINUS;
                                result_next.last       = 1'b0;
                            end
                            else
                            begin
                                bin_next = request.value;
                            end
                        end
                        OP_BYTE_DEC:
                        begin
                            bin_next = {{(VALUE_W-BYTE_W){1'b0}}, request.value[BYTE_W-1:0]};
                        end
                        OP_BYTE_BIN:
                        begin
                            bin_next   = {{(VALUE_W-BYTE_W){1'b0}}, request.value[BYTE_W-1:0]};
                            pos_next   = POS_W'(BYTE_W - 1);
                            state_next = ST_EMIT;
                        end
                        default:
                        begin
                            bin_next = request.value;
                        end
                    endcase
                end
            end

            ST_CONV:
            begin
                bcd_next     = {bcd_adj[BCD_W-2:0], bin_reg[VALUE_W-1]};
                bin_next     = {bin_reg[VALUE_W-2:0], 1'b0};
                bit_cnt_next = bit_cnt_reg + 1'b1;
                if (bit_cnt_reg == BIT_CNT_W'(VALUE_W - 1))
                begin
                    state_next = ST_EMIT;
                end
            end

            ST_EMIT:
            begin
                if (op_reg == OP_BYTE_BIN)
                begin
                    result_next.char_code = ASCII_ZERO + {7'd0, bin_reg[BYTE_W-1]};
                    bin_next              = {bin_reg[VALUE_W-2:0], 1'b0};
                end
                else
                begin
                    result_next.char_code = ASCII_ZERO + {4'd0, top_digit};
                    bcd_next              = {bcd_reg[BCD_W-5:0], 4'd0};
                end
                result_next.last = (pos_reg == '0);

                if (emit)
                begin
                    strobe_next = 1'b1;
                    seen_next   = 1'b1;
                end
                else
                begin
                    result_next = result_reg;
                end

                pos_next = pos_reg - 1'b1;
                if (pos_reg == '0)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            op_reg      <= OP_SIGNED_DEC;
            bin_reg     <= '0;
            bcd_reg     <= '0;
            bit_cnt_reg <= '0;
            pos_reg     <= '0;
            keep_reg    <= '0;
            seen_reg    <= 1'b0;
            strobe_reg  <= 1'b0;
            result_reg  <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            op_reg      <= op_next;
            bin_reg     <= bin_next;
            bcd_reg     <= bcd_next;
            bit_cnt_reg <= bit_cnt_next;
            pos_reg     <= pos_next;
            keep_reg    <= keep_next;
            seen_reg    <= seen_next;
            strobe_reg  <= strobe_next;
            result_reg  <= result_next;
        end
    end

    assign busy   = (state_reg != ST_IDLE);
    assign strobe = strobe_reg;
    assign result = result_reg;

endmodule
